FILE: rtl/core/mnpt_pkg.sv
// Shared types and constants for the MIDI note pairing tracker.
package mnpt_pkg;

  localparam int KIND_W      = 3;
  localparam int CH_W        = 4;
  localparam int KEY_W       = 7;
  localparam int VEL_W       = 7;
  localparam int PROG_W      = 7;
  localparam int RES_W       = 2;
  localparam int TICK_PORT_W = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = 7;

  localparam logic [CFG_W-1:0] SUSTAIN_CTRL_RESET  = 7'd64;
  localparam logic [CFG_W-1:0] PEDAL_THRESH_RESET  = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_CTRL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_THRESH = 1'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_NOTE_ON     = 3'd0,
    KIND_NOTE_OFF    = 3'd1,
    KIND_PROGRAM     = 3'd2,
    KIND_CONTROL     = 3'd3,
    KIND_TRACK_START = 3'd4
  } kind_e;

  typedef enum logic [RES_W-1:0] {
    RES_NOTE  = 2'd0,
    RES_PEDAL = 2'd1,
    RES_DROP  = 2'd2
  } result_e;

endpackage

FILE: rtl/core/mnpt_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
module mnpt_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/midi_note_pairing_tracker_unit.sv
// Top level of the MIDI note pairing tracker: event decode, queue control and result register.
// Pairs note-ons with later note-offs of the same channel and key, oldest first, through a
// bounded queue per key, tracks programs and sustain pedal spans per channel, and emits at most
// one result per event. Each event reads the head/count memory for its channel and key, then
// reads the ring memory at the queue head, then decides and writes back; that dependent pair
// of memory reads sets the rate. After reset and after every track-start event the head/count
// memory is swept to zero, one entry per cycle, over all CHANNELS * KEYS entries (2048 at the
// default size); no event is taken during the sweep, configuration writes are.
// A pending result waits in the output register while the next event is taken.
module midi_note_pairing_tracker_unit #(
  parameter int CHANNELS    = 16,
  parameter int KEYS        = 128,
  parameter int QUEUE_DEPTH = 4,
  parameter int TICK_WIDTH  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [mnpt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mnpt_pkg::CFG_W-1:0]          cfg_wdata_i,
  // event requests
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mnpt_pkg::KIND_W-1:0]         kind_i,
  input  logic [mnpt_pkg::CH_W-1:0]           channel_i,
  input  logic [mnpt_pkg::KEY_W-1:0]          key_i,
  input  logic [mnpt_pkg::VEL_W-1:0]          value_i,
  input  logic [mnpt_pkg::TICK_PORT_W-1:0]    tick_i,
  // result requests
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mnpt_pkg::RES_W-1:0]          result_kind_o,
  output logic [mnpt_pkg::CH_W-1:0]           out_channel_o,
  output logic [mnpt_pkg::PROG_W-1:0]         out_program_o,
  output logic [mnpt_pkg::KEY_W-1:0]          out_pitch_o,
  output logic [mnpt_pkg::VEL_W-1:0]          out_velocity_o,
  output logic [mnpt_pkg::TICK_PORT_W-1:0]    start_tick_o,
  output logic [mnpt_pkg::TICK_PORT_W-1:0]    length_ticks_o
);

  localparam int SLOTS    = CHANNELS * KEYS;
  localparam int SLOT_W   = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int ONSETS   = SLOTS * QUEUE_DEPTH;
  localparam int ONSET_AW = ONSETS > 1 ? $clog2(ONSETS) : 1;
  localparam int HEAD_W   = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int HC_W     = HEAD_W + CNT_W;
  localparam int CHI_W    = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam int ONSET_W  = TICK_WIDTH + mnpt_pkg::VEL_W;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_ONSET = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [SLOT_W-1:0] clr_q, clr_d;

  logic [mnpt_pkg::CFG_W-1:0] sus_ctrl_q, pedal_thr_q;

  // accepted event
  mnpt_pkg::kind_e               kind_q;
  logic [mnpt_pkg::CH_W-1:0]     channel_q;
  logic [mnpt_pkg::KEY_W-1:0]    key_q;
  logic [mnpt_pkg::VEL_W-1:0]    value_q;
  logic [TICK_WIDTH-1:0]         tick_q;

  // per-channel state
  logic [mnpt_pkg::PROG_W-1:0] prog_q [CHANNELS];
  logic [mnpt_pkg::PROG_W-1:0] prog_d [CHANNELS];
  logic                        down_q [CHANNELS];
  logic                        down_d [CHANNELS];
  logic [TICK_WIDTH-1:0]       pstart_q [CHANNELS];
  logic [TICK_WIDTH-1:0]       pstart_d [CHANNELS];

  // memory ports
  logic                 hc_we;
  logic [SLOT_W-1:0]    hc_waddr;
  logic [HC_W-1:0]      hc_wdata;
  logic [SLOT_W-1:0]    in_slot;
  logic [HC_W-1:0]      hc_rdata;
  logic                 on_we;
  logic [ONSET_AW-1:0]  on_waddr;
  logic [ONSET_AW-1:0]  on_raddr;
  logic [ONSET_W-1:0]   on_rdata;
  logic                 in_accept;

  // decode of the current event
  logic [SLOT_W-1:0]          cur_slot;
  logic [CHI_W-1:0]           ch_idx;
  logic                       ch_ok, key_ok;
  logic [HEAD_W-1:0]          q_head, q_head_next, q_tail;
  logic [HEAD_W:0]            tail_sum;
  logic [CNT_W-1:0]           q_cnt;
  logic                       q_full;
  logic [TICK_WIDTH-1:0]      on_start;
  logic [mnpt_pkg::VEL_W-1:0] on_vel;

  logic act_prog, act_press, act_release, act_push, act_pop, act_clear;
  logic need_emit, out_free, go;
  mnpt_pkg::result_e          em_kind;
  logic [mnpt_pkg::KEY_W-1:0] em_pitch;
  logic [mnpt_pkg::VEL_W-1:0] em_vel;
  logic [TICK_WIDTH-1:0]      em_start, em_len;

  // output register
  logic                            out_valid_q, out_valid_d;
  mnpt_pkg::result_e               res_kind_q;
  logic [mnpt_pkg::CH_W-1:0]       res_ch_q;
  logic [mnpt_pkg::PROG_W-1:0]     res_prog_q;
  logic [mnpt_pkg::KEY_W-1:0]      res_pitch_q;
  logic [mnpt_pkg::VEL_W-1:0]      res_vel_q;
  logic [mnpt_pkg::TICK_PORT_W-1:0] res_start_q, res_len_q;
  logic                            load_out;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_slot  = SLOT_W'(int'(channel_i) * KEYS + int'(key_i));
  assign cur_slot = SLOT_W'(int'(channel_q) * KEYS + int'(key_q));
  assign ch_idx   = CHI_W'(channel_q);
  assign ch_ok    = int'(channel_q) < CHANNELS;
  assign key_ok   = int'(key_q) < KEYS;

  assign q_head = hc_rdata[HC_W-1:CNT_W];
  assign q_cnt  = hc_rdata[CNT_W-1:0];
  assign q_full = q_cnt >= CNT_W'(QUEUE_DEPTH);

  assign tail_sum = {1'b0, q_head} + (HEAD_W+1)'(q_cnt);
  assign q_tail   = (tail_sum >= (HEAD_W+1)'(QUEUE_DEPTH))
                  ? HEAD_W'(tail_sum - (HEAD_W+1)'(QUEUE_DEPTH))
                  : HEAD_W'(tail_sum);
  assign q_head_next = (q_head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : q_head + 1'b1;

  assign on_raddr = ONSET_AW'(int'(cur_slot) * QUEUE_DEPTH + int'(q_head));
  assign on_waddr = ONSET_AW'(int'(cur_slot) * QUEUE_DEPTH + int'(q_tail));
  assign on_start = on_rdata[ONSET_W-1:mnpt_pkg::VEL_W];
  assign on_vel   = on_rdata[mnpt_pkg::VEL_W-1:0];

  mnpt_ram #(
    .DEPTH (SLOTS),
    .WIDTH (HC_W)
  ) u_hc_ram (
    .clk_i   (clk_i),
    .we_i    (hc_we),
    .waddr_i (hc_waddr),
    .wdata_i (hc_wdata),
    .re_i    (in_accept),
    .raddr_i (in_slot),
    .rdata_o (hc_rdata)
  );

  mnpt_ram #(
    .DEPTH (ONSETS),
    .WIDTH (ONSET_W)
  ) u_onset_ram (
    .clk_i   (clk_i),
    .we_i    (on_we),
    .waddr_i (on_waddr),
    .wdata_i ({tick_q, value_q}),
    .re_i    (state_q == S_ONSET),
    .raddr_i (on_raddr),
    .rdata_o (on_rdata)
  );

  // What the event does, before any back-pressure from the output side.
  always_comb begin
    act_prog    = 1'b0;
    act_press   = 1'b0;
    act_release = 1'b0;
    act_push    = 1'b0;
    act_pop     = 1'b0;
    act_clear   = 1'b0;
    need_emit   = 1'b0;
    em_kind     = mnpt_pkg::RES_NOTE;
    em_pitch    = key_q;
    em_vel      = value_q;
    em_start    = tick_q;
    em_len      = '0;
    unique case (kind_q)
      mnpt_pkg::KIND_TRACK_START: act_clear = 1'b1;
      mnpt_pkg::KIND_PROGRAM:     act_prog  = ch_ok;
      mnpt_pkg::KIND_CONTROL: begin
        if (ch_ok && key_q == sus_ctrl_q) begin
          if (value_q >= pedal_thr_q) begin
            act_press = !down_q[ch_idx];
          end else if (down_q[ch_idx]) begin
            act_release = 1'b1;
            need_emit   = 1'b1;
            em_kind     = mnpt_pkg::RES_PEDAL;
            em_pitch    = '0;
            em_vel      = '0;
            em_start    = pstart_q[ch_idx];
            em_len      = tick_q - pstart_q[ch_idx];
          end
        end
      end
      mnpt_pkg::KIND_NOTE_ON, mnpt_pkg::KIND_NOTE_OFF: begin
        if (ch_ok && key_ok) begin
          if (kind_q == mnpt_pkg::KIND_NOTE_ON && value_q != '0) begin
            if (q_full) begin
              need_emit = 1'b1;
              em_kind   = mnpt_pkg::RES_DROP;
            end else begin
              act_push = 1'b1;
            end
          end else if (q_cnt != '0 && tick_q >= on_start) begin
            // velocity-zero note-on lands here as a note-off
            act_pop   = 1'b1;
            need_emit = 1'b1;
            em_vel    = on_vel;
            em_start  = on_start;
            em_len    = tick_q - on_start;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign go       = !need_emit || out_free;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    hc_we       = 1'b0;
    hc_waddr    = cur_slot;
    hc_wdata    = '0;
    on_we       = 1'b0;
    load_out    = 1'b0;
    prog_d      = prog_q;
    down_d      = down_q;
    pstart_d    = pstart_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_CLEAR: begin
        hc_we    = 1'b1;
        hc_waddr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == SLOT_W'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_ONSET;
        end
      end
      S_ONSET: state_d = S_EXEC;
      S_EXEC: begin
        if (go) begin
          state_d = S_IDLE;
          if (act_prog) begin
            prog_d[ch_idx] = key_q;
          end
          if (act_press) begin
            down_d[ch_idx]   = 1'b1;
            pstart_d[ch_idx] = tick_q;
          end
          if (act_release) begin
            down_d[ch_idx] = 1'b0;
          end
          if (act_push) begin
            hc_we    = 1'b1;
            hc_wdata = {q_head, q_cnt + 1'b1};
            on_we    = 1'b1;
          end
          if (act_pop) begin
            hc_we    = 1'b1;
            hc_wdata = {q_head_next, q_cnt - 1'b1};
          end
          if (act_clear) begin
            for (int i = 0; i < CHANNELS; i++) begin
              prog_d[i] = '0;
              down_d[i] = 1'b0;
            end
            clr_d   = '0;
            state_d = S_CLEAR;
          end
          if (need_emit) begin
            load_out    = 1'b1;
            out_valid_d = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prog_q[i] <= '0;
        down_q[i] <= 1'b0;
      end
    end else begin
      prog_q <= prog_d;
      down_q <= down_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pstart_q <= pstart_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sus_ctrl_q  <= mnpt_pkg::SUSTAIN_CTRL_RESET;
      pedal_thr_q <= mnpt_pkg::PEDAL_THRESH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mnpt_pkg::CFG_SUSTAIN_CTRL: sus_ctrl_q  <= cfg_wdata_i;
        mnpt_pkg::CFG_PEDAL_THRESH: pedal_thr_q <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q    <= mnpt_pkg::kind_e'(kind_i);
      channel_q <= channel_i;
      key_q     <= key_i;
      value_q   <= value_i;
      tick_q    <= TICK_WIDTH'(tick_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_kind_q  <= em_kind;
      res_ch_q    <= channel_q;
      res_prog_q  <= prog_q[ch_idx];
      res_pitch_q <= em_pitch;
      res_vel_q   <= em_vel;
      res_start_q <= mnpt_pkg::TICK_PORT_W'(em_start);
      res_len_q   <= mnpt_pkg::TICK_PORT_W'(em_len);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = res_kind_q;
  assign out_channel_o  = res_ch_q;
  assign out_program_o  = res_prog_q;
  assign out_pitch_o    = res_pitch_q;
  assign out_velocity_o = res_vel_q;
  assign start_tick_o   = res_start_q;
  assign length_ticks_o = res_len_q;

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == S_ONSET)
    else $error("accepted event did not start the read sequence");

  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_we |-> !in_accept)
    else $error("head/count write collides with a read");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_we |-> hc_wdata[CNT_W-1:0] <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count written beyond depth");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_EXEC)
    else $error("result loaded outside the execute step");

endmodule

FILE: bench/mnpt_checker.sv
`timescale 1ns / 1ps
// Checker for the note pairing tracker: tracks pairing state, predicts results, compares.
module mnpt_checker #(
  parameter int CHANNELS    = 16,
  parameter int KEYS        = 128,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mnpt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mnpt_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                ev_valid_i,
  input  logic                                ev_stall_i,
  input  logic [mnpt_pkg::KIND_W-1:0]         kind_i,
  input  logic [mnpt_pkg::CH_W-1:0]           channel_i,
  input  logic [mnpt_pkg::KEY_W-1:0]          key_i,
  input  logic [mnpt_pkg::VEL_W-1:0]          value_i,
  input  logic [mnpt_pkg::TICK_PORT_W-1:0]    tick_i,
  input  logic                                res_valid_i,
  input  logic                                res_stall_i,
  input  logic [mnpt_pkg::RES_W-1:0]          res_kind_i,
  input  logic [mnpt_pkg::CH_W-1:0]           res_channel_i,
  input  logic [mnpt_pkg::PROG_W-1:0]         res_program_i,
  input  logic [mnpt_pkg::KEY_W-1:0]          res_pitch_i,
  input  logic [mnpt_pkg::VEL_W-1:0]          res_velocity_i,
  input  logic [mnpt_pkg::TICK_PORT_W-1:0]    res_start_i,
  input  logic [mnpt_pkg::TICK_PORT_W-1:0]    res_length_i,
  output int                                  fails_o,
  output int                                  backlog_o
);
  import mnpt_pkg::*;

  localparam int SLOTS = CHANNELS * KEYS;

  typedef struct packed {
    result_e                 kind;
    logic [CH_W-1:0]         channel;
    logic [PROG_W-1:0]       prog;
    logic [KEY_W-1:0]        pitch;
    logic [VEL_W-1:0]        velocity;
    logic [TICK_PORT_W-1:0]  start;
    logic [TICK_PORT_W-1:0]  length;
  } outcome_t;

  outcome_t                outcome_q[$];
  int                      mismatches = 0;

  logic [TICK_PORT_W-1:0]  onset_tick_mem [SLOTS*QUEUE_DEPTH];
  logic [VEL_W-1:0]        onset_vel_mem  [SLOTS*QUEUE_DEPTH];
  int unsigned             head_of [SLOTS];
  int unsigned             fill_of [SLOTS];
  logic [PROG_W-1:0]       program_of [CHANNELS];
  logic                    pedal_held [CHANNELS];
  logic [TICK_PORT_W-1:0]  pedal_from [CHANNELS];
  logic [CFG_W-1:0]        sustain_num;
  logic [CFG_W-1:0]        press_level;

  assign fails_o = mismatches;

  task automatic clear_track();
    for (int s = 0; s < SLOTS; s++) begin
      head_of[s] = 0;
      fill_of[s] = 0;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      program_of[c] = '0;
      pedal_held[c] = 1'b0;
    end
  endtask

  task automatic add_outcome(input result_e kind, input logic [CH_W-1:0] ch,
                             input logic [KEY_W-1:0] pitch, input logic [VEL_W-1:0] vel,
                             input logic [TICK_PORT_W-1:0] start,
                             input logic [TICK_PORT_W-1:0] length);
    outcome_t o;
    o.kind     = kind;
    o.channel  = ch;
    o.prog     = program_of[ch];
    o.pitch    = pitch;
    o.velocity = vel;
    o.start    = start;
    o.length   = length;
    outcome_q.push_back(o);
  endtask

  task automatic track_event(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
                             input logic [KEY_W-1:0] key, input logic [VEL_W-1:0] val,
                             input logic [TICK_PORT_W-1:0] tick);
    int unsigned            slot;
    int unsigned            pos;
    logic [TICK_PORT_W-1:0] first;
    slot = ch * KEYS + key;
    if (kind == KIND_TRACK_START) begin
      clear_track();
    end else if (kind == KIND_PROGRAM) begin
      program_of[ch] = key;
    end else if (kind == KIND_CONTROL) begin
      if (key == sustain_num) begin
        if (val >= press_level) begin
          // re-press keeps the first start
          if (!pedal_held[ch]) begin
            pedal_held[ch] = 1'b1;
            pedal_from[ch] = tick;
          end
        end else if (pedal_held[ch]) begin
          pedal_held[ch] = 1'b0;
          add_outcome(RES_PEDAL, ch, '0, '0, pedal_from[ch], tick - pedal_from[ch]);
        end
      end
    end else if (kind == KIND_NOTE_ON && val != '0) begin
      if (fill_of[slot] >= QUEUE_DEPTH) begin
        add_outcome(RES_DROP, ch, key, val, tick, '0);
      end else begin
        pos = slot * QUEUE_DEPTH + (head_of[slot] + fill_of[slot]) % QUEUE_DEPTH;
        onset_tick_mem[pos] = tick;
        onset_vel_mem[pos]  = val;
        fill_of[slot]++;
      end
    end else if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) begin
      // note-off, or note-on at velocity zero: pair with the oldest onset if it has started
      if (fill_of[slot] != 0) begin
        pos   = slot * QUEUE_DEPTH + head_of[slot];
        first = onset_tick_mem[pos];
        if (tick >= first) begin
          add_outcome(RES_NOTE, ch, key, onset_vel_mem[pos], first, tick - first);
          head_of[slot] = (head_of[slot] + 1) % QUEUE_DEPTH;
          fill_of[slot]--;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      clear_track();
      sustain_num = SUSTAIN_CTRL_RESET;
      press_level = PEDAL_THRESH_RESET;
      outcome_q.delete();
      backlog_o <= 0;
    end else begin
      if (res_valid_i && !res_stall_i) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result mismatch, expected none, actual kind %0d channel %0d pitch %0d",
                   $time, res_kind_i, res_channel_i, res_pitch_i);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(res_kind_i));
          check_field("out_channel", 32'(want.channel), 32'(res_channel_i));
          check_field("out_program", 32'(want.prog), 32'(res_program_i));
          check_field("out_pitch", 32'(want.pitch), 32'(res_pitch_i));
          check_field("out_velocity", 32'(want.velocity), 32'(res_velocity_i));
          check_field("start_tick", want.start, res_start_i);
          check_field("length_ticks", want.length, res_length_i);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SUSTAIN_CTRL) sustain_num = cfg_wdata_i;
        else if (cfg_idx_i == CFG_PEDAL_THRESH) press_level = cfg_wdata_i;
      end
      if (ev_valid_i && !ev_stall_i)
        track_event(kind_i, channel_i, key_i, value_i, tick_i);
      backlog_o <= outcome_q.size();
    end
  end

endmodule

FILE: bench/tb_midi_note_pairing_tracker_unit.sv
`timescale 1ns / 1ps
// Top of the note pairing tracker bench: clock, reset, event stimulus, settings and verdict.
module tb_midi_note_pairing_tracker_unit;
  import mnpt_pkg::*;

  localparam int LIMIT = 400000;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx   = CFG_SUSTAIN_CTRL;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    ev_valid  = 1'b0;
  logic [KIND_W-1:0]       ev_kind   = KIND_NOTE_OFF;
  logic [CH_W-1:0]         ev_channel = '0;
  logic [KEY_W-1:0]        ev_key    = '0;
  logic [VEL_W-1:0]        ev_value  = '0;
  logic [TICK_PORT_W-1:0]  ev_tick   = '0;
  logic                    res_stall = 1'b0;

  logic                    ev_stall;
  logic                    res_valid;
  logic [RES_W-1:0]        res_kind;
  logic [CH_W-1:0]         res_channel;
  logic [PROG_W-1:0]       res_program;
  logic [KEY_W-1:0]        res_pitch;
  logic [VEL_W-1:0]        res_velocity;
  logic [TICK_PORT_W-1:0]  res_start;
  logic [TICK_PORT_W-1:0]  res_length;

  int                      fails;
  int                      backlog;
  int unsigned             cycles = 0;
  logic                    calm = 1'b0;
  logic [CFG_W-1:0]        sustain_num = SUSTAIN_CTRL_RESET;
  logic [CFG_W-1:0]        press_level = PEDAL_THRESH_RESET;
  logic [TICK_PORT_W-1:0]  now = 32'd1000;

  midi_note_pairing_tracker_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (ev_valid),
    .in_stall_o     (ev_stall),
    .kind_i         (ev_kind),
    .channel_i      (ev_channel),
    .key_i          (ev_key),
    .value_i        (ev_value),
    .tick_i         (ev_tick),
    .out_valid_o    (res_valid),
    .out_stall_i    (res_stall),
    .result_kind_o  (res_kind),
    .out_channel_o  (res_channel),
    .out_program_o  (res_program),
    .out_pitch_o    (res_pitch),
    .out_velocity_o (res_velocity),
    .start_tick_o   (res_start),
    .length_ticks_o (res_length)
  );

  mnpt_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .ev_valid_i     (ev_valid),
    .ev_stall_i     (ev_stall),
    .kind_i         (ev_kind),
    .channel_i      (ev_channel),
    .key_i          (ev_key),
    .value_i        (ev_value),
    .tick_i         (ev_tick),
    .res_valid_i    (res_valid),
    .res_stall_i    (res_stall),
    .res_kind_i     (res_kind),
    .res_channel_i  (res_channel),
    .res_program_i  (res_program),
    .res_pitch_i    (res_pitch),
    .res_velocity_i (res_velocity),
    .res_start_i    (res_start),
    .res_length_i   (res_length),
    .fails_o        (fails),
    .backlog_o      (backlog)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_stall <= !calm && ($urandom_range(99) < 8);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_event(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
                            input logic [KEY_W-1:0] key, input logic [VEL_W-1:0] val,
                            input logic [TICK_PORT_W-1:0] tick);
    if (!calm && $urandom_range(99) < 8) begin
      ev_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    ev_valid   <= 1'b1;
    ev_kind    <= kind;
    ev_channel <= ch;
    ev_key     <= key;
    ev_value   <= val;
    ev_tick    <= tick;
    @(posedge clk);
    while (ev_stall) @(posedge clk);
  endtask

  // drain every pending result, then give the pipeline time to settle
  task automatic quiesce();
    ev_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_settings(input logic [CFG_W-1:0] ctrl, input logic [CFG_W-1:0] level);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SUSTAIN_CTRL;
    cfg_wdata <= ctrl;
    @(posedge clk);
    cfg_idx   <= CFG_PEDAL_THRESH;
    cfg_wdata <= level;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sustain_num = ctrl;
    press_level = level;
  endtask

  task automatic run_phase(input int count, input logic with_calm);
    logic [CH_W-1:0]        chans [3];
    logic [KEY_W-1:0]       keys [4];
    logic [KIND_W-1:0]      kind;
    logic [CH_W-1:0]        ch;
    logic [KEY_W-1:0]       key;
    logic [VEL_W-1:0]       val;
    logic [TICK_PORT_W-1:0] t;
    int                     r;
    // a small pool of channels and keys so that onsets and releases meet
    foreach (chans[j]) chans[j] = CH_W'($urandom_range(15));
    foreach (keys[j]) keys[j] = KEY_W'($urandom_range(127));
    for (int i = 0; i < count; i++) begin
      calm <= with_calm && i >= count / 4 && i < count * 3 / 4;
      now = now + $urandom_range(0, 40);
      t = now;
      if ($urandom_range(99) < 3) t = now - $urandom_range(1, 50);
      else if ($urandom_range(99) == 0) t = $urandom();
      if ($urandom_range(9) == 0) begin
        ch  = CH_W'($urandom_range(15));
        key = KEY_W'($urandom_range(127));
      end else begin
        ch  = chans[$urandom_range(2)];
        key = keys[$urandom_range(3)];
      end
      val = VEL_W'($urandom_range(127));
      r = $urandom_range(99);
      if (r < 42) begin
        kind = KIND_NOTE_ON;
        val  = ($urandom_range(99) < 6) ? '0 : VEL_W'($urandom_range(1, 127));
      end else if (r < 72) begin
        kind = KIND_NOTE_OFF;
      end else if (r < 80) begin
        kind = KIND_PROGRAM;
        key  = KEY_W'($urandom_range(127));
      end else if (r < 96) begin
        kind = KIND_CONTROL;
        if ($urandom_range(99) < 80) key = sustain_num;
        if ($urandom_range(9) == 0) val = VEL_W'($urandom_range(127));
        else if ($urandom_range(1) == 1 || press_level == '0)
          val = VEL_W'($urandom_range(127, press_level));
        else val = VEL_W'($urandom_range(press_level - 1, 0));
      end else if (r < 99) begin
        kind = KIND_W'(KIND_TRACK_START + $urandom_range(1, 3));
      end else begin
        kind = KIND_TRACK_START;
      end
      send_event(kind, ch, key, val, t);
    end
    calm <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // widest note, program carried into the result
    send_event(KIND_PROGRAM, 4'd15, 7'd127, 7'd0, 32'd0);
    send_event(KIND_NOTE_ON, 4'd15, 7'd127, 7'd127, 32'd0);
    send_event(KIND_NOTE_OFF, 4'd15, 7'd127, 7'd0, 32'hFFFF_FFFF);
    send_event(KIND_NOTE_OFF, 4'd15, 7'd127, 7'd127, 32'hFFFF_FFFF);
    // release ahead of its onset, then velocity-zero onset as a release
    send_event(KIND_NOTE_ON, 4'd0, 7'd0, 7'd1, 32'd100);
    send_event(KIND_NOTE_OFF, 4'd0, 7'd0, 7'd5, 32'd50);
    send_event(KIND_NOTE_ON, 4'd0, 7'd0, 7'd0, 32'd120);
    // overflow one key queue
    for (int i = 0; i < 5; i++)
      send_event(KIND_NOTE_ON, 4'd3, 7'd60, 7'(10 + i), 32'(200 + i));
    send_event(KIND_NOTE_OFF, 4'd3, 7'd60, 7'd64, 32'd300);
    // pedal span: press, re-press, release, stray release, other controller
    send_event(KIND_CONTROL, 4'd2, SUSTAIN_CTRL_RESET, PEDAL_THRESH_RESET, 32'd400);
    send_event(KIND_CONTROL, 4'd2, SUSTAIN_CTRL_RESET, 7'd127, 32'd410);
    send_event(KIND_CONTROL, 4'd2, SUSTAIN_CTRL_RESET, VEL_W'(PEDAL_THRESH_RESET - 1),
               32'd500);
    send_event(KIND_CONTROL, 4'd2, SUSTAIN_CTRL_RESET, 7'd0, 32'd510);
    send_event(KIND_CONTROL, 4'd2, 7'd10, 7'd127, 32'd520);
    for (int i = 1; i <= 3; i++)
      send_event(KIND_W'(KIND_TRACK_START + i), 4'd9, 7'd85, 7'd42, 32'h5555_AAAA);
    // state left open across a track start must be gone afterwards
    send_event(KIND_CONTROL, 4'd0, SUSTAIN_CTRL_RESET, 7'd100, 32'd600);
    send_event(KIND_NOTE_ON, 4'd5, 7'd7, 7'd33, 32'd700);
    send_event(KIND_TRACK_START, 4'd0, 7'd0, 7'd0, 32'd750);
    send_event(KIND_CONTROL, 4'd0, SUSTAIN_CTRL_RESET, 7'd0, 32'd800);
    send_event(KIND_NOTE_OFF, 4'd5, 7'd7, 7'd0, 32'd900);
    send_event(KIND_NOTE_ON, 4'd15, 7'd127, 7'd99, 32'd910);
    send_event(KIND_NOTE_OFF, 4'd15, 7'd127, 7'd0, 32'd950);

    write_settings(SUSTAIN_CTRL_RESET, PEDAL_THRESH_RESET);
    run_phase(400, 1'b0);
    write_settings(7'd0, 7'd0);
    run_phase(400, 1'b1);
    write_settings(7'd127, 7'd127);
    run_phase(400, 1'b0);
    write_settings(CFG_W'($urandom_range(127)), CFG_W'($urandom_range(127)));
    run_phase(400, 1'b0);

    quiesce();
    if (fails == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
